@@ sv/fdtd_1d_field_step_unit_defines.svh @@
// Assertion macros for the FDTD field step unit.
`ifndef FDTD_1D_FIELD_STEP_UNIT_DEFINES_SVH
`define FDTD_1D_FIELD_STEP_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define FDTD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fdtd step unit check failed");
`define FDTD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fdtd step unit check failed");
`else
`define FDTD_ASSERT_SAME(label, ante, cons)
`define FDTD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ sv/fdtd_pkg.sv @@
// Shared constants, types and saturation helper for the FDTD field step unit.
package fdtd_pkg;

  localparam int CELLS      = 2048;
  localparam int IDX_W      = $clog2(CELLS);
  localparam int FX_W       = 32;
  localparam int COEF_W     = FX_W + 1;
  localparam int PROD_W     = FX_W + COEF_W;
  localparam int FRAC_BITS  = 24;
  localparam int RND_W      = PROD_W - FRAC_BITS;
  localparam int SUM_W      = RND_W + 1;
  localparam int MAG_W      = FX_W - 1;
  localparam int CFG_IDX_W  = 3;
  localparam int IFC_W      = 12;
  localparam int SEL_W      = 11;

  localparam logic [IDX_W-1:0] LAST_CELL = IDX_W'(CELLS - 1);
  localparam logic [IDX_W-1:0] PREV_LAST = IDX_W'(CELLS - 2);
  localparam logic [IDX_W-1:0] FIRST_INNER = IDX_W'(1);

  localparam logic signed [COEF_W-1:0] MUR_COEF   = COEF_W'(-10066330);
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(2 ** (FRAC_BITS - 1));

  localparam logic [CFG_IDX_W-1:0] REG_H_COEF_LEFT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_H_COEF_RIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_E_COEF_LEFT  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_E_COEF_RIGHT = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_INTERFACE    = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE       = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_PROBE        = CFG_IDX_W'(6);

  localparam logic [FX_W-1:0]  H_COEF_RST = 32'd167772;
  localparam logic [FX_W-1:0]  E_COEF_RST = 32'd419430400;
  localparam logic [IFC_W-1:0] IFC_RST    = 12'd1024;
  localparam logic [SEL_W-1:0] SRC_RST    = 11'd256;
  localparam logic [SEL_W-1:0] PRB_RST    = 11'd384;

  typedef struct packed {
    logic                     valid;
    logic [IDX_W-1:0]         idx;
    logic signed [FX_W-1:0]   a;
    logic signed [FX_W-1:0]   b;
    logic signed [FX_W-1:0]   acc;
    logic signed [COEF_W-1:0] coef;
    logic signed [FX_W-1:0]   aux;
  } cell_in_t;

  typedef struct packed {
    logic                   valid;
    logic [IDX_W-1:0]       idx;
    logic signed [FX_W-1:0] value;
    logic signed [FX_W-1:0] aux;
  } cell_out_t;

  function automatic logic signed [FX_W-1:0] sat_fx(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-FX_W:0] hi;
    hi = v[SUM_W-1:FX_W-1];
    if (hi == '0 || hi == '1) begin
      return v[FX_W-1:0];
    end
    return v[SUM_W-1] ? {1'b1, {(FX_W-1){1'b0}}} : {1'b0, {(FX_W-1){1'b1}}};
  endfunction

endpackage

@@ sv/fdtd_if.sv @@
// Handshake channels of the FDTD field step unit: step items, results, register writes.
interface fdtd_step_if;
  import fdtd_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [FX_W-1:0] source_amplitude;
  logic                   in_window;
  logic                   start_pass;
  modport source (output valid, source_amplitude, in_window, start_pass, input ready);
  modport sink (input valid, source_amplitude, in_window, start_pass, output ready);
endinterface

interface fdtd_result_if;
  import fdtd_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [FX_W-1:0] probe_field;
  logic [MAG_W-1:0]       peak_magnitude;
  modport source (output valid, probe_field, peak_magnitude, input ready);
  modport sink (input valid, probe_field, peak_magnitude, output ready);
endinterface

interface fdtd_cfg_if;
  import fdtd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [FX_W-1:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ sv/fdtd_cell.sv @@
// Pipelined update cell: acc + round(sat(a - b) * coef), saturated, four stages.
module fdtd_cell (
  input  logic                clk,
  input  logic                rst,
  input  fdtd_pkg::cell_in_t  cin,
  output fdtd_pkg::cell_out_t cout
);
  import fdtd_pkg::*;

  logic                     v1, v2, v3, v4;
  logic [IDX_W-1:0]         idx1, idx2, idx3, idx4;
  logic signed [FX_W-1:0]   acc1, acc2, acc3;
  logic signed [FX_W-1:0]   aux1, aux2, aux3, aux4;
  logic signed [FX_W-1:0]   diff1;
  logic signed [COEF_W-1:0] coef1;
  logic signed [PROD_W-1:0] prod2;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [RND_W-1:0]  rnd3;
  logic signed [FX_W-1:0]   value4;

  assign prod_rnd = prod2 + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= cin.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    diff1  <= sat_fx(SUM_W'(cin.a) - SUM_W'(cin.b));
    coef1  <= cin.coef;
    acc1   <= cin.acc;
    aux1   <= cin.aux;
    idx1   <= cin.idx;
    prod2  <= diff1 * coef1;
    acc2   <= acc1;
    aux2   <= aux1;
    idx2   <= idx1;
    rnd3   <= prod_rnd[PROD_W-1:FRAC_BITS];
    acc3   <= acc2;
    aux3   <= aux2;
    idx3   <= idx2;
    value4 <= sat_fx(SUM_W'(acc3) + SUM_W'(rnd3));
    aux4   <= aux3;
    idx4   <= idx3;
  end

  always_comb begin
    cout.valid = v4;
    cout.idx   = idx4;
    cout.value = value4;
    cout.aux   = aux4;
  end

endmodule

@@ sv/fdtd_1d_field_step_unit.sv @@
// Top level of the 1D FDTD field step unit: sequencer, field memories and cell chain.
//
// Usage:
//   step   : one item per time step (source_amplitude, in_window, start_pass).
//   result : one item per step (probe_field, peak_magnitude).
//   cfg    : register writes (index, data), always ready; write only while idle.
// One step streams every cell through a chain of three update cells (magnetic,
// electric, boundary), one cell per cycle, reading and writing the two field
// memories at one address each per cycle. The next step is accepted once the
// result has moved to the output register. start_pass clears fields and peak
// for that step by reading the memories as zero during its sweep; that sweep
// rewrites every electric cell and every magnetic cell but the last.
// Reset: registers take their default values, the first step after reset runs
// as if start_pass were set, so no memory clearing pass is needed.
// A stalled receiver holds the result in the output register; the unit still
// accepts and runs one more step, then waits with that result until the
// output register is free.
`include "fdtd_1d_field_step_unit_defines.svh"

module fdtd_1d_field_step_unit (
  input  logic                 clk,
  input  logic                 rst,
  fdtd_step_if.sink            step,
  fdtd_result_if.source        result,
  fdtd_cfg_if.sink             cfg
);
  import fdtd_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SWEEP = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_TAIL  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]             state;
  logic                   fresh;
  logic                   accept;
  logic                   out_free;

  logic [FX_W-1:0]        h_coef_left, h_coef_right, e_coef_left, e_coef_right;
  logic [IFC_W-1:0]       interface_cell;
  logic [SEL_W-1:0]       source_cell, probe_cell;

  logic signed [FX_W-1:0] amp_q;
  logic                   window_q;
  logic                   clr_q;

  logic signed [FX_W-1:0] e_mem [CELLS];
  logic signed [FX_W-1:0] h_mem [CELLS];

  logic [IDX_W-1:0]       rd_idx, rd_idx_q, h_ra;
  logic                   rd_valid;
  logic signed [FX_W-1:0] e_rd, h_rd, e_old, h_old, e_prev, h_prev;
  logic signed [FX_W-1:0] e0_old, e1_old, en_old, elast_old, mur_lo;

  cell_in_t               h_in, e_in, mur_in;
  cell_out_t              h_out, e_out, mur_out;

  logic                   e_we;
  logic [IDX_W-1:0]       e_wa;
  logic signed [FX_W-1:0] e_wraw, e_wv;

  logic signed [FX_W-1:0] probe_val, abs_fx;
  logic [MAG_W-1:0]       mag, peak_value, peak_base, peak_next;
  logic                   result_valid;
  logic signed [FX_W-1:0] result_probe;
  logic [MAG_W-1:0]       result_peak;

  assign step.ready = (state == ST_IDLE);
  assign accept     = step.valid && step.ready;
  assign cfg.ready  = 1'b1;
  assign out_free   = !result_valid || result.ready;

  assign result.valid          = result_valid;
  assign result.probe_field    = result_probe;
  assign result.peak_magnitude = result_peak;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_coef_left    <= H_COEF_RST;
      h_coef_right   <= H_COEF_RST;
      e_coef_left    <= E_COEF_RST;
      e_coef_right   <= E_COEF_RST;
      interface_cell <= IFC_RST;
      source_cell    <= SRC_RST;
      probe_cell     <= PRB_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_H_COEF_LEFT:  h_coef_left    <= cfg.data;
        REG_H_COEF_RIGHT: h_coef_right   <= cfg.data;
        REG_E_COEF_LEFT:  e_coef_left    <= cfg.data;
        REG_E_COEF_RIGHT: e_coef_right   <= cfg.data;
        REG_INTERFACE:    interface_cell <= cfg.data[IFC_W-1:0];
        REG_SOURCE:       source_cell    <= cfg.data[SEL_W-1:0];
        REG_PROBE:        probe_cell     <= cfg.data[SEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      fresh        <= 1'b1;
      rd_valid     <= 1'b0;
      peak_value   <= '0;
      result_valid <= 1'b0;
    end else begin
      rd_valid <= (state == ST_SWEEP);
      if (state == ST_DONE && out_free) begin
        result_valid <= 1'b1;
      end else if (result.ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) state <= ST_SWEEP;
        end
        ST_SWEEP: begin
          if (rd_idx == LAST_CELL) state <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (mur_out.valid && mur_out.idx == LAST_CELL) state <= ST_TAIL;
        end
        ST_TAIL: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            state      <= ST_IDLE;
            peak_value <= peak_next;
            fresh      <= 1'b0;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      amp_q     <= step.source_amplitude;
      window_q  <= step.in_window;
      clr_q     <= step.start_pass | fresh;
      probe_val <= '0;
    end else if (e_we && 32'(e_wa) == 32'(probe_cell)) begin
      probe_val <= e_wv;
    end
    if (state == ST_SWEEP) begin
      rd_idx <= rd_idx + IDX_W'(1);
    end else begin
      rd_idx <= '0;
    end
    rd_idx_q <= rd_idx;
    if (state == ST_DONE && out_free) begin
      result_probe <= probe_val;
      result_peak  <= peak_next;
    end
  end

  assign h_ra = rd_idx - IDX_W'(1);

  always_ff @(posedge clk) begin
    if (state == ST_SWEEP) begin
      e_rd <= e_mem[rd_idx];
    end
    if (e_we) begin
      e_mem[e_wa] <= e_wv;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SWEEP) begin
      h_rd <= h_mem[h_ra];
    end
    if (h_out.valid) begin
      h_mem[h_out.idx] <= h_out.value;
    end
  end

  assign e_old = clr_q ? '0 : e_rd;
  assign h_old = clr_q ? '0 : h_rd;

  always_ff @(posedge clk) begin
    if (rd_valid) begin
      e_prev <= e_old;
      if (rd_idx_q == '0)         e0_old    <= e_old;
      if (rd_idx_q == FIRST_INNER) e1_old   <= e_old;
      if (rd_idx_q == PREV_LAST)  en_old    <= e_old;
      if (rd_idx_q == LAST_CELL)  elast_old <= e_old;
    end
    if (h_out.valid) begin
      h_prev <= h_out.value;
    end
    if (mur_out.valid && mur_out.idx == '0) begin
      mur_lo <= mur_out.value;
    end
  end

  always_comb begin
    h_in.valid = rd_valid && (rd_idx_q != '0);
    h_in.idx   = rd_idx_q - IDX_W'(1);
    h_in.a     = e_old;
    h_in.b     = e_prev;
    h_in.acc   = h_old;
    h_in.coef  = (32'(h_in.idx) < 32'(interface_cell)) ? {1'b0, h_coef_left}
                                                        : {1'b0, h_coef_right};
    h_in.aux   = e_prev;

    e_in.valid = h_out.valid && (h_out.idx != '0);
    e_in.idx   = h_out.idx;
    e_in.a     = h_out.value;
    e_in.b     = h_prev;
    e_in.acc   = h_out.aux;
    e_in.coef  = (32'(h_out.idx) < 32'(interface_cell)) ? {1'b0, e_coef_left}
                                                         : {1'b0, e_coef_right};
    e_in.aux   = '0;

    mur_in.valid = e_out.valid && (e_out.idx == FIRST_INNER || e_out.idx == PREV_LAST);
    mur_in.idx   = (e_out.idx == FIRST_INNER) ? '0 : LAST_CELL;
    mur_in.a     = e_out.value;
    mur_in.b     = (e_out.idx == FIRST_INNER) ? e0_old : elast_old;
    mur_in.acc   = (e_out.idx == FIRST_INNER) ? e1_old : en_old;
    mur_in.coef  = MUR_COEF;
    mur_in.aux   = '0;
  end

  fdtd_cell u_h_cell (.clk(clk), .rst(rst), .cin(h_in), .cout(h_out));
  fdtd_cell u_e_cell (.clk(clk), .rst(rst), .cin(e_in), .cout(e_out));
  fdtd_cell u_mur_cell (.clk(clk), .rst(rst), .cin(mur_in), .cout(mur_out));

  always_comb begin
    e_we   = 1'b0;
    e_wa   = e_out.idx;
    e_wraw = e_out.value;
    if (e_out.valid) begin
      e_we = 1'b1;
    end else if (state == ST_DRAIN && mur_out.valid && mur_out.idx == LAST_CELL) begin
      e_we   = 1'b1;
      e_wa   = LAST_CELL;
      e_wraw = mur_out.value;
    end else if (state == ST_TAIL) begin
      e_we   = 1'b1;
      e_wa   = '0;
      e_wraw = mur_lo;
    end
    e_wv = (32'(e_wa) == 32'(source_cell)) ? sat_fx(SUM_W'(e_wraw) + SUM_W'(amp_q))
                                           : e_wraw;
  end

  always_comb begin
    abs_fx    = probe_val[FX_W-1] ? -probe_val : probe_val;
    mag       = abs_fx[FX_W-1] ? '1 : abs_fx[MAG_W-1:0];
    peak_base = clr_q ? '0 : peak_value;
    peak_next = (window_q && mag > peak_base) ? mag : peak_base;
  end

  `FDTD_ASSERT_SAME(a_e_stream_in_sweep, e_out.valid, state == ST_SWEEP || state == ST_DRAIN)
  `FDTD_ASSERT_SAME(a_mur_last_in_drain, mur_out.valid && mur_out.idx == LAST_CELL, state == ST_DRAIN)
  `FDTD_ASSERT_NEXT(a_done_gives_result, state == ST_DONE && out_free, result.valid && state == ST_IDLE)

endmodule
